// ===== hdl/rdst_pkg.sv =====
`default_nettype none

package rdst_pkg;

   localparam int DEFAULT_MAX_ROWS  = 2048;
   localparam int DEFAULT_MAX_WIDTH = 4096;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 14;
   localparam int COORD_W  = 16;
   localparam int RWIDTH_W = 13;
   localparam int RCOUNT_W = 12;
   localparam int ROW_W    = 11;
   localparam int COL_W    = 13;
   localparam int FRAME_W  = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [ROW_W-1:0]          row_type;
   typedef logic [COL_W-1:0]          col_type;
   typedef logic [FRAME_W-1:0]        frame_type;

   localparam cmd_type CMD_MARK_PIXEL = 3'd0;
   localparam cmd_type CMD_MARK_RECT  = 3'd1;
   localparam cmd_type CMD_MARK_ALL   = 3'd2;
   localparam cmd_type CMD_CLEAR      = 3'd3;
   localparam cmd_type CMD_PRESENT    = 3'd4;

   localparam logic [0:0] REG_ROW_WIDTH = 1'b0;
   localparam logic [0:0] REG_ROW_COUNT = 1'b1;

   localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RESET = 13'd1920;
   localparam logic [RCOUNT_W-1:0] ROW_COUNT_RESET = 12'd1080;
   localparam frame_type           FRAME_RESET     = 32'd1;

   localparam logic MODE_WIDEN = 1'b0;
   localparam logic MODE_SCAN  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/rdst_channels.sv =====
`default_nettype none

interface rdst_req_if;
   logic                valid;
   logic                ready;
   rdst_pkg::cmd_type   command;
   rdst_pkg::pos_type   pos_x;
   rdst_pkg::pos_type   pos_y;
   rdst_pkg::pos_type   rect_width;
   rdst_pkg::pos_type   rect_height;

   modport source (output valid, command, pos_x, pos_y, rect_width, rect_height,
                   input ready);
   modport sink (input valid, command, pos_x, pos_y, rect_width, rect_height,
                 output ready);
endinterface

interface rdst_rsp_if;
   logic                 valid;
   logic                 ready;
   rdst_pkg::row_type    row;
   rdst_pkg::col_type    span_start;
   rdst_pkg::col_type    span_end;
   logic                 has_span;
   logic                 done_res;
   rdst_pkg::frame_type  frame_count;

   modport source (output valid, row, span_start, span_end, has_span, done_res,
                   frame_count, input ready);
   modport sink (input valid, row, span_start, span_end, has_span, done_res,
                 frame_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/rdst_span_unit.sv =====
`default_nettype none

module rdst_span_unit #(
   parameter int FW = 12,
   parameter int AW = 13
) (
   input  wire logic             mode,
   input  wire logic [FW+AW:0]   entry_i,
   input  wire logic [FW-1:0]    x0_i,
   input  wire logic [AW-1:0]    x1_i,
   input  wire logic [AW-1:0]    rw_i,
   output logic      [FW+AW:0]   entry_o,
   output logic                  hit_o,
   output logic      [AW-1:0]    end_o
);

   logic          dirty;
   logic [FW-1:0] first;
   logic [AW-1:0] after;
   logic [FW-1:0] new_first;
   logic [AW-1:0] new_after;

   assign dirty = entry_i[FW+AW];
   assign first = entry_i[FW+AW-1:AW];
   assign after = entry_i[AW-1:0];

   assign new_first = (!dirty || (x0_i < first)) ? x0_i : first;
   assign new_after = (!dirty || (x1_i > after)) ? x1_i : after;

   assign end_o = (after < rw_i) ? after : rw_i;
   assign hit_o = (mode == rdst_pkg::MODE_SCAN) && dirty && (end_o > AW'(first));

   always_comb begin
      case (mode)
         rdst_pkg::MODE_WIDEN: entry_o = {1'b1, new_first, new_after};
         rdst_pkg::MODE_SCAN:  entry_o = {1'b0, first, after};
         default:              entry_o = entry_i;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/row_damage_span_tracker.sv =====
`default_nettype none

// Row damage tracker with one dirty column span per row, held in a single-port row
// memory with a registered read, and a dirty row range in registers. Pixel and
// rectangle marks and present steps visit rows through one shared span unit that
// widens a span or clips and tests it; a rectangle mark visits each covered row.
// Mark-all writes every row on screen, and clear every row of the memory, without
// the span unit. A present-next step scans rows until the next dirty span, or until
// the end of the range, where the done transaction follows. After reset the row
// memory is swept row by row, during which no transaction is accepted. Each row
// visit through the span unit is one read and one write of the row memory.
module row_damage_span_tracker #(
   parameter int MAX_ROWS  = rdst_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_WIDTH = rdst_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rdst_req_if.sink                                 req_ch,
   rdst_rsp_if.source                               rsp_ch,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [rdst_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [rdst_pkg::CSR_W-1:0]          pwdata,
   output logic      [rdst_pkg::CSR_W-1:0]          prdata,
   output logic                                     pready
);

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RBW = $clog2(MAX_ROWS + 1);
   localparam int FW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int AW  = $clog2(MAX_WIDTH + 1);
   localparam int EW  = 1 + FW + AW;
   localparam int CW  = rdst_pkg::COORD_W;
   localparam int PW  = rdst_pkg::POS_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CLEAR    = 3'd1;
   localparam logic [2:0] ST_FILL     = 3'd2;
   localparam logic [2:0] ST_READ     = 3'd3;
   localparam logic [2:0] ST_MODIFY   = 3'd4;
   localparam logic [2:0] ST_SPAN_OUT = 3'd5;
   localparam logic [2:0] ST_DONE_OUT = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [rdst_pkg::RWIDTH_W-1:0]  row_width_ff, row_width_in;
   logic [rdst_pkg::RCOUNT_W-1:0]  row_count_ff, row_count_in;
   logic [RBW-1:0]                 row_ptr_ff, row_ptr_in;
   logic [RBW-1:0]                 row_end_ff, row_end_in;
   logic [FW-1:0]                  x0_ff, x0_in;
   logic [AW-1:0]                  x1_ff, x1_in;
   logic                           mode_ff, mode_in;
   logic [RBW-1:0]                 range_top_ff, range_top_in;
   logic [RBW-1:0]                 range_bottom_ff, range_bottom_in;
   logic                           range_valid_ff, range_valid_in;
   rdst_pkg::frame_type            frame_ff, frame_in;
   logic [FW-1:0]                  pend_s_ff, pend_s_in;
   logic [AW-1:0]                  pend_e_ff, pend_e_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rdst_pkg::row_type              rsp_row_ff, rsp_row_in;
   rdst_pkg::col_type              rsp_start_ff, rsp_start_in;
   rdst_pkg::col_type              rsp_end_ff, rsp_end_in;
   logic                           rsp_has_ff, rsp_has_in;
   logic                           rsp_done_ff, rsp_done_in;
   rdst_pkg::frame_type            rsp_frame_ff, rsp_frame_in;

   logic [EW-1:0]                  mem [MAX_ROWS];
   logic [EW-1:0]                  rd_data_ff;
   logic                           mem_we;
   logic [EW-1:0]                  mem_wd;

   logic [AW-1:0]                  eff_w;
   logic [RBW-1:0]                 eff_r;
   logic                           slot_free;
   logic                           accept;
   logic                           csr_write;

   rdst_pkg::coord_type            xs, ys, ws, hs, rw_s, rc_s;
   rdst_pkg::coord_type            rx0, rx1, ry0, ry1;
   rdst_pkg::coord_type            mk_x0, mk_x1, mk_y0, mk_y1;
   logic                           mk_ok;
   logic [RBW-1:0]                 y0_r, y1_r;
   logic [RBW-1:0]                 scan_end;
   logic [RBW-1:0]                 ptr_next;

   logic [EW-1:0]                  unit_entry;
   logic                           unit_hit;
   logic [AW-1:0]                  unit_end;

   rdst_span_unit #(
      .FW (FW),
      .AW (AW)
   ) u_span (
      .mode    (mode_ff),
      .entry_i (rd_data_ff),
      .x0_i    (x0_ff),
      .x1_i    (x1_ff),
      .rw_i    (eff_w),
      .entry_o (unit_entry),
      .hit_o   (unit_hit),
      .end_o   (unit_end)
   );

   assign eff_w = (row_width_ff >= MAX_WIDTH) ? AW'(MAX_WIDTH) : AW'(row_width_ff);
   assign eff_r = (row_count_ff >= MAX_ROWS) ? RBW'(MAX_ROWS) : RBW'(row_count_ff);

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         rdst_pkg::REG_ROW_WIDTH: prdata = rdst_pkg::CSR_W'(row_width_ff);
         rdst_pkg::REG_ROW_COUNT: prdata = rdst_pkg::CSR_W'(row_count_ff);
         default:                 prdata = '0;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.row         = rsp_row_ff;
   assign rsp_ch.span_start  = rsp_start_ff;
   assign rsp_ch.span_end    = rsp_end_ff;
   assign rsp_ch.has_span    = rsp_has_ff;
   assign rsp_ch.done_res    = rsp_done_ff;
   assign rsp_ch.frame_count = rsp_frame_ff;

   assign xs   = {{(CW-PW){req_ch.pos_x[PW-1]}}, req_ch.pos_x};
   assign ys   = {{(CW-PW){req_ch.pos_y[PW-1]}}, req_ch.pos_y};
   assign ws   = {{(CW-PW){req_ch.rect_width[PW-1]}}, req_ch.rect_width};
   assign hs   = {{(CW-PW){req_ch.rect_height[PW-1]}}, req_ch.rect_height};
   assign rw_s = CW'(eff_w);
   assign rc_s = CW'(eff_r);

   always_comb begin
      rx0 = xs[CW-1] ? '0 : xs;
      ry0 = ys[CW-1] ? '0 : ys;
      rx1 = xs + ws;
      ry1 = ys + hs;
      if (rx1 > rw_s) begin
         rx1 = rw_s;
      end
      if (ry1 > rc_s) begin
         ry1 = rc_s;
      end
      if (req_ch.command == rdst_pkg::CMD_MARK_PIXEL) begin
         mk_x0 = xs;
         mk_x1 = xs + CW'(1);
         mk_y0 = ys;
         mk_y1 = ys + CW'(1);
         mk_ok = !xs[CW-1] && !ys[CW-1] && (xs < rw_s) && (ys < rc_s);
      end else begin
         mk_x0 = rx0;
         mk_x1 = rx1;
         mk_y0 = ry0;
         mk_y1 = ry1;
         mk_ok = (rx1 > rx0) && (ry1 > ry0);
      end
   end

   assign y0_r     = mk_y0[RBW-1:0];
   assign y1_r     = mk_y1[RBW-1:0];
   assign scan_end = (range_bottom_ff < eff_r) ? range_bottom_ff : eff_r;
   assign ptr_next = row_ptr_ff + RBW'(1);

   always_comb begin
      state_in        = state_ff;
      row_width_in    = row_width_ff;
      row_count_in    = row_count_ff;
      row_ptr_in      = row_ptr_ff;
      row_end_in      = row_end_ff;
      x0_in           = x0_ff;
      x1_in           = x1_ff;
      mode_in         = mode_ff;
      range_top_in    = range_top_ff;
      range_bottom_in = range_bottom_ff;
      range_valid_in  = range_valid_ff;
      frame_in        = frame_ff;
      pend_s_in       = pend_s_ff;
      pend_e_in       = pend_e_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_row_in      = rsp_row_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_end_in      = rsp_end_ff;
      rsp_has_in      = rsp_has_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_frame_in    = rsp_frame_ff;
      mem_we          = 1'b0;
      mem_wd          = unit_entry;

      if (csr_write) begin
         case (paddr[2])
            rdst_pkg::REG_ROW_WIDTH: row_width_in = pwdata[rdst_pkg::RWIDTH_W-1:0];
            rdst_pkg::REG_ROW_COUNT: row_count_in = pwdata[rdst_pkg::RCOUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.command)
                  rdst_pkg::CMD_MARK_PIXEL, rdst_pkg::CMD_MARK_RECT: begin
                     if (mk_ok) begin
                        x0_in      = mk_x0[FW-1:0];
                        x1_in      = mk_x1[AW-1:0];
                        row_ptr_in = y0_r;
                        row_end_in = y1_r;
                        mode_in    = rdst_pkg::MODE_WIDEN;
                        state_in   = ST_READ;
                        range_valid_in = 1'b1;
                        if (!range_valid_ff || (y0_r < range_top_ff)) begin
                           range_top_in = y0_r;
                        end
                        if (!range_valid_ff || (y1_r > range_bottom_ff)) begin
                           range_bottom_in = y1_r;
                        end
                     end
                  end
                  rdst_pkg::CMD_MARK_ALL: begin
                     if (eff_r != '0) begin
                        range_valid_in  = 1'b1;
                        range_top_in    = '0;
                        range_bottom_in = eff_r;
                        row_ptr_in      = '0;
                        row_end_in      = eff_r;
                        state_in        = ST_FILL;
                     end
                  end
                  rdst_pkg::CMD_CLEAR: begin
                     range_valid_in  = 1'b0;
                     range_top_in    = '0;
                     range_bottom_in = '0;
                     row_ptr_in      = '0;
                     state_in        = ST_CLEAR;
                  end
                  rdst_pkg::CMD_PRESENT: begin
                     if (range_valid_ff) begin
                        if (range_top_ff < scan_end) begin
                           row_ptr_in = range_top_ff;
                           row_end_in = scan_end;
                           mode_in    = rdst_pkg::MODE_SCAN;
                           state_in   = ST_READ;
                        end else begin
                           state_in = ST_DONE_OUT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = '0;
            if (row_ptr_ff == RBW'(MAX_ROWS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               row_ptr_in = ptr_next;
            end
         end
         ST_FILL: begin
            mem_we     = 1'b1;
            mem_wd     = {1'b1, {FW{1'b0}}, eff_w};
            row_ptr_in = ptr_next;
            if (ptr_next == row_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            mem_we = 1'b1;
            if (unit_hit) begin
               pend_s_in    = rd_data_ff[FW+AW-1:AW];
               pend_e_in    = unit_end;
               range_top_in = ptr_next;
               state_in     = ST_SPAN_OUT;
            end else if (ptr_next == row_end_ff) begin
               state_in = (mode_ff == rdst_pkg::MODE_SCAN) ? ST_DONE_OUT : ST_IDLE;
            end else begin
               row_ptr_in = ptr_next;
               state_in   = ST_READ;
            end
         end
         ST_SPAN_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = rdst_pkg::ROW_W'(row_ptr_ff);
               rsp_start_in = rdst_pkg::COL_W'(pend_s_ff);
               rsp_end_in   = rdst_pkg::COL_W'(pend_e_ff);
               rsp_has_in   = 1'b1;
               rsp_done_in  = 1'b0;
               rsp_frame_in = frame_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE_OUT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_row_in      = '0;
               rsp_start_in    = '0;
               rsp_end_in      = '0;
               rsp_has_in      = 1'b0;
               rsp_done_in     = 1'b1;
               rsp_frame_in    = frame_ff + 32'd1;
               frame_in        = frame_ff + 32'd1;
               range_valid_in  = 1'b0;
               range_top_in    = '0;
               range_bottom_in = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[row_ptr_ff[RW-1:0]] <= mem_wd;
      end
      rd_data_ff <= mem[row_ptr_ff[RW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         row_width_ff    <= rdst_pkg::ROW_WIDTH_RESET;
         row_count_ff    <= rdst_pkg::ROW_COUNT_RESET;
         row_ptr_ff      <= '0;
         row_end_ff      <= '0;
         mode_ff         <= rdst_pkg::MODE_WIDEN;
         range_top_ff    <= '0;
         range_bottom_ff <= '0;
         range_valid_ff  <= 1'b0;
         frame_ff        <= rdst_pkg::FRAME_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_width_ff    <= row_width_in;
         row_count_ff    <= row_count_in;
         row_ptr_ff      <= row_ptr_in;
         row_end_ff      <= row_end_in;
         mode_ff         <= mode_in;
         range_top_ff    <= range_top_in;
         range_bottom_ff <= range_bottom_in;
         range_valid_ff  <= range_valid_in;
         frame_ff        <= frame_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      pend_s_ff    <= pend_s_in;
      pend_e_ff    <= pend_e_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   // A transaction is either a span or the end of a present, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_has_ff && rsp_done_ff))
      else $error("response carries both a span and the done flag");

   // Finishing a present clears the row range as the done transaction is issued.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE_OUT) && slot_free |=> rsp_valid_ff && rsp_done_ff && !range_valid_ff)
      else $error("done transaction issued without clearing the row range");

   // Row visits stay inside the row interval set up when the transaction was taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> (row_ptr_ff < row_end_ff))
      else $error("row pointer left its interval");

   // A present without damage gives no response and leaves the block idle.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.command == rdst_pkg::CMD_PRESENT) && !range_valid_ff
      |=> (state_ff == ST_IDLE) && (frame_ff == $past(frame_ff)))
      else $error("present without damage changed the block state");

endmodule

`default_nettype wire

// ===== verif/row_damage_span_tracker_tb.sv =====
`default_nettype none

module row_damage_span_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = rdst_pkg::DEFAULT_MAX_ROWS;
   localparam int COLS = rdst_pkg::DEFAULT_MAX_WIDTH;
   localparam int SETTLE_CYCLES = 2 * ROWS + 200;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int QUIET_LIMIT = 40000;

   typedef struct {
      rdst_pkg::cmd_type command;
      rdst_pkg::pos_type pos_x;
      rdst_pkg::pos_type pos_y;
      rdst_pkg::pos_type rect_width;
      rdst_pkg::pos_type rect_height;
   } damage_cmd_type;

   typedef struct {
      rdst_pkg::row_type   row;
      rdst_pkg::col_type   span_start;
      rdst_pkg::col_type   span_end;
      logic                has_span;
      logic                done_res;
      rdst_pkg::frame_type frame_count;
   } span_result_type;

   typedef enum int {NO_RESULT, SPAN_RESULT, DONE_RESULT} present_outcome_type;

   class span_predictor;
      logic [rdst_pkg::RWIDTH_W-1:0] row_width;
      logic [rdst_pkg::RCOUNT_W-1:0] row_count;
      int first_col [ROWS];
      int after_col [ROWS];
      bit dirty [ROWS];
      int range_top;
      int range_bottom;
      bit range_on;
      rdst_pkg::frame_type frames;
      span_result_type expected_spans [$];
      int errors;
      int checked;
      int spans;
      int rounds;

      function new();
         row_width = rdst_pkg::ROW_WIDTH_RESET;
         row_count = rdst_pkg::ROW_COUNT_RESET;
         foreach (dirty[i]) begin
            dirty[i] = 1'b0;
            first_col[i] = 0;
            after_col[i] = 0;
         end
         range_top = 0;
         range_bottom = 0;
         range_on = 1'b0;
         frames = rdst_pkg::FRAME_RESET;
      endfunction

      function void set_reg(logic [0:0] index, logic [31:0] value);
         if (index == rdst_pkg::REG_ROW_WIDTH)
            row_width = value[rdst_pkg::RWIDTH_W-1:0];
         else
            row_count = value[rdst_pkg::RCOUNT_W-1:0];
      endfunction

      function void widen_row(int y, int x0, int x1);
         if (!dirty[y]) begin
            dirty[y] = 1'b1;
            first_col[y] = x0;
            after_col[y] = x1;
         end else begin
            if (x0 < first_col[y]) first_col[y] = x0;
            if (x1 > after_col[y]) after_col[y] = x1;
         end
      endfunction

      function void widen_range(int y0, int y1);
         if (!range_on) begin
            range_on = 1'b1;
            range_top = y0;
            range_bottom = y1;
         end else begin
            if (y0 < range_top) range_top = y0;
            if (y1 > range_bottom) range_bottom = y1;
         end
      endfunction

      function present_outcome_type apply_command(damage_cmd_type it);
         int x, y, w, h, rw, rc, x0, y0, x1, y1, lim, s, e;
         span_result_type res;
         x = it.pos_x;
         y = it.pos_y;
         w = it.rect_width;
         h = it.rect_height;
         rw = int'(row_width) < COLS ? int'(row_width) : COLS;
         rc = int'(row_count) < ROWS ? int'(row_count) : ROWS;
         case (it.command)
            rdst_pkg::CMD_MARK_PIXEL: begin
               if (x >= 0 && y >= 0 && x < rw && y < rc) begin
                  widen_row(y, x, x + 1);
                  widen_range(y, y + 1);
               end
            end
            rdst_pkg::CMD_MARK_RECT: begin
               x0 = x < 0 ? 0 : x;
               y0 = y < 0 ? 0 : y;
               x1 = x + w;
               y1 = y + h;
               if (x1 > rw) x1 = rw;
               if (y1 > rc) y1 = rc;
               if (x1 > x0 && y1 > y0) begin
                  for (int r = y0; r < y1; r++) widen_row(r, x0, x1);
                  widen_range(y0, y1);
               end
            end
            rdst_pkg::CMD_MARK_ALL: begin
               if (rc > 0) begin
                  for (int r = 0; r < rc; r++) begin
                     dirty[r] = 1'b1;
                     first_col[r] = 0;
                     after_col[r] = rw;
                  end
                  range_on = 1'b1;
                  range_top = 0;
                  range_bottom = rc;
               end
            end
            rdst_pkg::CMD_CLEAR: begin
               foreach (dirty[r]) dirty[r] = 1'b0;
               range_on = 1'b0;
               range_top = 0;
               range_bottom = 0;
            end
            rdst_pkg::CMD_PRESENT: begin
               if (!range_on) return NO_RESULT;
               lim = range_bottom < rc ? range_bottom : rc;
               for (int r = range_top; r < lim; r++) begin
                  if (dirty[r]) begin
                     s = first_col[r];
                     e = after_col[r] < rw ? after_col[r] : rw;
                     dirty[r] = 1'b0;
                     if (e > s) begin
                        range_top = r + 1;
                        res.row = rdst_pkg::row_type'(r);
                        res.span_start = rdst_pkg::col_type'(s);
                        res.span_end = rdst_pkg::col_type'(e);
                        res.has_span = 1'b1;
                        res.done_res = 1'b0;
                        res.frame_count = frames;
                        expected_spans.push_back(res);
                        spans++;
                        return SPAN_RESULT;
                     end
                  end
               end
               range_on = 1'b0;
               range_top = 0;
               range_bottom = 0;
               frames = frames + 1;
               res.row = '0;
               res.span_start = '0;
               res.span_end = '0;
               res.has_span = 1'b0;
               res.done_res = 1'b1;
               res.frame_count = frames;
               expected_spans.push_back(res);
               rounds++;
               return DONE_RESULT;
            end
            default: ;
         endcase
         return NO_RESULT;
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_span(span_result_type got);
         span_result_type want;
         if (expected_spans.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, row %0d span %0d..%0d done %0d",
                     $time, got.row, got.span_start, got.span_end, got.done_res);
            return;
         end
         want = expected_spans.pop_front();
         checked++;
         compare("row", 32'(want.row), 32'(got.row));
         compare("span_start", 32'(want.span_start), 32'(got.span_start));
         compare("span_end", 32'(want.span_end), 32'(got.span_end));
         compare("has_span", 32'(want.has_span), 32'(got.has_span));
         compare("done_res", 32'(want.done_res), 32'(got.done_res));
         compare("frame_count", want.frame_count, got.frame_count);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [rdst_pkg::CSR_ADDR_W-1:0] paddr;
   logic [rdst_pkg::CSR_W-1:0] pwdata;
   logic [rdst_pkg::CSR_W-1:0] prdata;
   logic pready;

   rdst_req_if req_ch ();
   rdst_rsp_if rsp_ch ();

   span_predictor board = new();
   present_outcome_type last_outcome;
   bit sender_gaps;
   bit receiver_stalls;
   bit holdoff_req;
   int requests_sent;
   int geometries;
   int quiet_cycles;

   row_damage_span_tracker DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin : result_monitor
      span_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.row = rsp_ch.row;
         got.span_start = rsp_ch.span_start;
         got.span_end = rsp_ch.span_end;
         got.has_span = rsp_ch.has_span;
         got.done_res = rsp_ch.done_res;
         got.frame_count = rsp_ch.frame_count;
         board.check_span(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("row_damage_span_tracker_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic rdst_pkg::pos_type any_pos();
      return rdst_pkg::pos_type'($urandom);
   endfunction

   function automatic rdst_pkg::pos_type pick_coord(int limit);
      case ($urandom_range(0, 9))
         0: return rdst_pkg::pos_type'($urandom);
         1: return rdst_pkg::pos_type'(-int'($urandom_range(1, 8)));
         2: return rdst_pkg::pos_type'(limit - 1 + int'($urandom_range(0, 2)));
         default: return rdst_pkg::pos_type'(limit > 0 ? int'($urandom_range(0, limit - 1)) : 0);
      endcase
   endfunction

   function automatic rdst_pkg::pos_type pick_size(int limit);
      int top_size;
      top_size = limit / 4 + 2;
      if (top_size > 64) top_size = 64;
      case ($urandom_range(0, 9))
         0: return rdst_pkg::pos_type'($urandom);
         1: return rdst_pkg::pos_type'(-int'($urandom_range(0, 4)));
         2: return rdst_pkg::pos_type'(limit + int'($urandom_range(0, 8)));
         default: return rdst_pkg::pos_type'($urandom_range(1, top_size));
      endcase
   endfunction

   task automatic send(rdst_pkg::cmd_type c, rdst_pkg::pos_type x, rdst_pkg::pos_type y,
                       rdst_pkg::pos_type w, rdst_pkg::pos_type h);
      damage_cmd_type it;
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      it.command = c;
      it.pos_x = x;
      it.pos_y = y;
      it.rect_width = w;
      it.rect_height = h;
      req_ch.valid <= 1'b1;
      req_ch.command <= c;
      req_ch.pos_x <= x;
      req_ch.pos_y <= y;
      req_ch.rect_width <= w;
      req_ch.rect_height <= h;
      do @(posedge clock); while (!req_ch.ready);
      last_outcome = board.apply_command(it);
      requests_sent++;
   endtask

   task automatic present_all();
      do send(rdst_pkg::CMD_PRESENT, any_pos(), any_pos(), any_pos(), any_pos());
      while (last_outcome == SPAN_RESULT);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.expected_spans.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      board.set_reg(index, value);
   endtask

   task automatic configure(logic [31:0] width, logic [31:0] height);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(rdst_pkg::REG_ROW_WIDTH, width);
      csr_write(rdst_pkg::REG_ROW_COUNT, height);
      geometries++;
   endtask

   task automatic run_random(int quota, bit allow_all, int rw, int rc);
      int counted, marks, pick;
      rdst_pkg::cmd_type c;
      counted = 0;
      while (counted < quota) begin
         if ($urandom_range(0, 9) < 7) begin
            marks = $urandom_range(1, 6);
            repeat (marks) begin
               pick = $urandom_range(0, 19);
               if (pick == 0 && allow_all)
                  send(rdst_pkg::CMD_MARK_ALL, any_pos(), any_pos(), any_pos(), any_pos());
               else if (pick == 1)
                  send(rdst_pkg::CMD_CLEAR, any_pos(), any_pos(), any_pos(), any_pos());
               else if (pick < 8)
                  send(rdst_pkg::CMD_MARK_RECT, pick_coord(rw), pick_coord(rc),
                       pick_size(rw), pick_size(rc));
               else
                  send(rdst_pkg::CMD_MARK_PIXEL, pick_coord(rw), pick_coord(rc), any_pos(),
                       any_pos());
            end
            counted += marks;
            if ($urandom_range(0, 4) != 0) begin
               do begin
                  send(rdst_pkg::CMD_PRESENT, any_pos(), any_pos(), any_pos(), any_pos());
                  counted++;
               end while (last_outcome == SPAN_RESULT && $urandom_range(0, 15) != 0);
            end
         end else begin
            c = rdst_pkg::cmd_type'($urandom_range(0, 7));
            send(c, any_pos(), any_pos(), any_pos(), any_pos());
            if (c <= rdst_pkg::CMD_PRESENT) counted++;
         end
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.command = rdst_pkg::CMD_MARK_PIXEL;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.rect_width = '0;
      req_ch.rect_height = '0;
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      holdoff_req = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send(rdst_pkg::CMD_MARK_PIXEL, 0, 0, 0, 0);
      send(rdst_pkg::CMD_MARK_PIXEL, 1919, 1079, 0, 0);
      send(rdst_pkg::CMD_MARK_PIXEL, 1920, 5, 0, 0);
      send(rdst_pkg::CMD_MARK_PIXEL, 5, 1080, 0, 0);
      send(rdst_pkg::CMD_MARK_PIXEL, -1, 3, 0, 0);
      send(rdst_pkg::CMD_MARK_PIXEL, 8191, -8192, -1, -8192);
      send(rdst_pkg::CMD_MARK_RECT, -8192, -8192, 8191, 8191);
      send(rdst_pkg::CMD_MARK_RECT, 1900, 1075, 100, 100);
      send(rdst_pkg::CMD_MARK_RECT, 10, 10, 0, 5);
      send(rdst_pkg::CMD_MARK_RECT, 10, 10, 5, -3);
      send(rdst_pkg::CMD_MARK_RECT, -5, -5, 12, 14);
      for (int c = int'(rdst_pkg::CMD_PRESENT) + 1; c < 8; c++)
         send(rdst_pkg::cmd_type'(c), any_pos(), any_pos(), any_pos(), any_pos());
      present_all();
      send(rdst_pkg::CMD_PRESENT, 0, 0, 0, 0);
      send(rdst_pkg::CMD_MARK_ALL, 0, 0, 0, 0);
      send(rdst_pkg::CMD_CLEAR, 0, 0, 0, 0);
      send(rdst_pkg::CMD_PRESENT, 0, 0, 0, 0);

      configure(32'd64, 32'd32);
      run_random(175, 1'b1, 64, 32);
      drain();
      run_random(175, 1'b1, 64, 32);

      configure(32'd8191, 32'd4095);
      send(rdst_pkg::CMD_MARK_PIXEL, 4095, 2047, 0, 0);
      send(rdst_pkg::CMD_MARK_PIXEL, 4096, 0, 0, 0);
      send(rdst_pkg::CMD_MARK_ALL, 0, 0, 0, 0);
      send(rdst_pkg::CMD_CLEAR, 0, 0, 0, 0);
      send(rdst_pkg::CMD_MARK_RECT, -100, -100, 8191, 8191);
      send(rdst_pkg::CMD_CLEAR, 0, 0, 0, 0);
      run_random(40, 1'b0, 4096, 2048);
      send(rdst_pkg::CMD_MARK_PIXEL, 3000, 0, 0, 0);
      send(rdst_pkg::CMD_MARK_RECT, 2000, 1500, 100, 3);

      // Narrow and short screen: the spans left behind clip to nothing, and
      // rows below the single screen row stay dirty until a clear.
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      configure(32'd1, 32'd1);
      present_all();
      run_random(120, 1'b1, 1, 1);

      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      configure(32'd0, 32'd16);
      send(rdst_pkg::CMD_MARK_ALL, 0, 0, 0, 0);
      present_all();
      run_random(80, 1'b1, 0, 16);

      configure(32'd20, 32'd0);
      send(rdst_pkg::CMD_MARK_ALL, 0, 0, 0, 0);
      present_all();
      run_random(60, 1'b1, 20, 0);

      configure(32'd4096, 32'd2048);
      run_random(30, 1'b0, 4096, 2048);
      send(rdst_pkg::CMD_CLEAR, 0, 0, 0, 0);

      configure(32'd200, 32'd100);
      run_random(200, 1'b1, 200, 100);
      send(rdst_pkg::CMD_MARK_ALL, 0, 0, 0, 0);
      holdoff_req = 1'b1;
      present_all();
      run_random(200, 1'b1, 200, 100);

      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      configure(32'd13, 32'd40);
      run_random(300, 1'b1, 13, 40);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.expected_spans.size() != 0) begin
         $display("%0t: %0d expected transactions never arrived", $time,
                  board.expected_spans.size());
         board.errors += board.expected_spans.size();
      end
      $display("Sent %0d commands across %0d screen geometries.", requests_sent, geometries);
      $display("Checked %0d transactions: %0d row spans and %0d finished presents.",
               board.checked, board.spans, board.rounds);
      if (board.errors == 0)
         $display("row_damage_span_tracker_tb: done, clean");
      else
         $display("row_damage_span_tracker_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/rdst_pkg.sv
hdl/rdst_channels.sv
hdl/rdst_span_unit.sv
hdl/row_damage_span_tracker.sv
verif/row_damage_span_tracker_tb.sv
